// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the period meter.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, but also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/icpm_pkg.sv =====
// Types and constants of the input capture period meter.
// No dependencies; used by icpm_core and input_capture_period_meter.
package icpm_pkg;

	// Event codes carried in the command field
	typedef enum logic [1:0] {
		CMD_OVERFLOW = 2'd0,
		CMD_CAPTURE  = 2'd1,
		CMD_REARM    = 2'd2
	} cmd_t;

	// Measurement phases
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam int unsigned STAMP_W  = 16;
	localparam int unsigned OVF_W    = 8;
	localparam int unsigned PERIOD_W = 32;
	localparam logic [OVF_W-1:0] OVF_MAX = 8'd255;

	// One input event
	typedef struct packed {
		logic [1:0]         command;
		logic [STAMP_W-1:0] capture_time;
	} evt_t;

	// One result
	typedef struct packed {
		logic [1:0]          capture_phase;
		logic [PERIOD_W-1:0] period_cycles;
		logic                period_ready;
	} res_t;

endpackage

// ===== sv/icpm_core.sv =====
// Measurement state and next-state logic of the period meter.
// Depends on icpm_pkg; instantiated by input_capture_period_meter.
module icpm_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  icpm_pkg::evt_t item,
	output icpm_pkg::res_t res
);
	import icpm_pkg::*;

	phase_t               phase_q, phase_d;
	logic [STAMP_W-1:0]   start_q, start_d;
	logic [STAMP_W-1:0]   end_q, end_d;
	logic [OVF_W-1:0]     ovf_q, ovf_d;
	logic [PERIOD_W-1:0]  period_q, period_d;
	logic [PERIOD_W-1:0]  period_calc;
	logic                 ready_d;

	// overflows * 65536 + end - start, wrapping at 32 bits
	assign period_calc = {{(PERIOD_W-OVF_W-STAMP_W){1'b0}}, ovf_q, {STAMP_W{1'b0}}}
		+ {{(PERIOD_W-STAMP_W){1'b0}}, item.capture_time}
		- {{(PERIOD_W-STAMP_W){1'b0}}, start_q};

	// Event decode
	always_comb begin
		phase_d  = phase_q;
		start_d  = start_q;
		end_d    = end_q;
		ovf_d    = ovf_q;
		period_d = period_q;
		ready_d  = 1'b0;
		case (item.command)
			CMD_OVERFLOW: begin
				// counted only while armed, saturating
				if ((phase_q == PH_FIRST || phase_q == PH_SECOND) && ovf_q != OVF_MAX) begin
					ovf_d = ovf_q + 8'd1;
				end
			end
			CMD_CAPTURE: begin
				if (phase_q == PH_FIRST) begin
					start_d = item.capture_time;
					ovf_d   = '0;
					phase_d = PH_SECOND;
				end else if (phase_q == PH_SECOND) begin
					end_d    = item.capture_time;
					period_d = period_calc;
					phase_d  = PH_DONE;
					ready_d  = 1'b1;
				end
			end
			CMD_REARM: begin
				start_d = end_q;
				ovf_d   = '0;
				phase_d = PH_SECOND;
			end
			default: begin
				// unused code: no change
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			start_q  <= '0;
			end_q    <= '0;
			ovf_q    <= '0;
			period_q <= '0;
		end else if (en) begin
			phase_q  <= phase_d;
			start_q  <= start_d;
			end_q    <= end_d;
			ovf_q    <= ovf_d;
			period_q <= period_d;
		end
	end

	assign res.capture_phase = phase_d;
	assign res.period_cycles = period_d;
	assign res.period_ready  = ready_d;

endmodule

// ===== sv/input_capture_period_meter.sv =====
// Top level of the input capture period meter: input register, core, result register.
// Depends on icpm_pkg, icpm_core and assert_macros.svh.
//
// Usage:
//   evt channel (evt_valid / evt_stall / evt) takes one event per transaction:
//   timer overflow, edge capture with its timer stamp, or rearm.
//   res channel (res_valid / res_stall / res) returns exactly one result per
//   event: phase after the event, held period value, and a flag set when the
//   event completed a new period.
//   An accepted transaction is held in the input register, then registered in the result register, before it is on res.
//   Throughput: one event per clock while res_stall is low; the state update is one add/compare pass
//   between the input register and the result register.
//   Stall: while res_stall holds, the result register keeps its transaction and
//   one more event waits in the input register; evt_stall then rises.
//   Reset (arst_n low): phase awaits first edge, stamps, overflow count and
//   period clear to zero, both registers empty.
`include "assert_macros.svh"
module input_capture_period_meter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_valid,
	output logic           evt_stall,
	input  icpm_pkg::evt_t evt,
	output logic           res_valid,
	input  logic           res_stall,
	output icpm_pkg::res_t res
);
	import icpm_pkg::*;

	logic valid_s1;
	evt_t evt_s1;
	logic advance;
	res_t res_d;
	logic res_valid_q;
	res_t res_q;

	// Stage 1 moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign evt_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
	end

	icpm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (evt_s1),
		.res    (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	`ASSERT_CLK(a_ready_done, res_valid |-> (!res.period_ready || res.capture_phase == PH_DONE), "period_ready without done phase")
	`ASSERT_ALWAYS(a_stall_full, evt_stall |-> valid_s1, "input stalled with empty stage")
	`ASSERT_CLK(a_advance_out, advance |=> res_valid, "result lost after advance")

endmodule

// ===== tb/input_capture_period_meter_tb.sv =====
// Self-checking testbench for input_capture_period_meter: random event traffic with random
// gaps and result stalls, every result compared against an in-bench phase/period tracker.
// Depends on icpm_pkg and the input_capture_period_meter RTL.
`timescale 1ns / 100ps

module input_capture_period_meter_tb;
	import icpm_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_EVENTS = 500;
	localparam int MAX_REPORTS = 100;

	// Tracks the meter's phase, stamps and overflow count, and holds the results still owed
	class period_tracker;
		phase_t phase;
		logic [STAMP_W-1:0] start_stamp;
		logic [STAMP_W-1:0] end_stamp;
		logic [OVF_W-1:0] ovf_count;
		logic [PERIOD_W-1:0] period;
		res_t pending_results[$];
		int errors;
		int periods_done;
		int saturated_ovf;

		function new();
			phase = PH_FIRST;
			start_stamp = '0;
			end_stamp = '0;
			ovf_count = '0;
			period = '0;
			errors = 0;
			periods_done = 0;
			saturated_ovf = 0;
		endfunction

		// Apply one accepted event and queue the result it owes
		function void note_event(evt_t e);
			res_t r;
			r.period_ready = 1'b0;
			case (e.command)
				CMD_OVERFLOW: begin
					if (phase != PH_DONE) begin
						if (ovf_count < OVF_MAX)
							ovf_count = ovf_count + 1'b1;
						else
							saturated_ovf++;
					end
				end
				CMD_CAPTURE: begin
					if (phase == PH_FIRST) begin
						start_stamp = e.capture_time;
						ovf_count = '0;
						phase = PH_SECOND;
					end else if (phase == PH_SECOND) begin
						end_stamp = e.capture_time;
						period = PERIOD_W'(end_stamp) - PERIOD_W'(start_stamp)
							+ (PERIOD_W'(ovf_count) << STAMP_W);
						phase = PH_DONE;
						r.period_ready = 1'b1;
						periods_done++;
					end
				end
				CMD_REARM: begin
					start_stamp = end_stamp;
					ovf_count = '0;
					phase = PH_SECOND;
				end
				default: begin
				end
			endcase
			r.capture_phase = phase;
			r.period_cycles = period;
			pending_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest owed one
		function void check_result(res_t got);
			res_t exp;
			bit bad;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result phase %0d period %0h ready %0b",
						$time, got.capture_phase, got.period_cycles, got.period_ready);
				return;
			end
			exp = pending_results.pop_front();
			bad = (got.capture_phase !== exp.capture_phase)
				|| (got.period_cycles !== exp.period_cycles)
				|| (got.period_ready !== exp.period_ready);
			if (bad) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch exp phase %0d period %0h ready %0b, got phase %0d period %0h ready %0b",
						$time, exp.capture_phase, exp.period_cycles, exp.period_ready,
						got.capture_phase, got.period_cycles, got.period_ready);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;
	logic res_valid;
	logic res_stall;
	res_t res;

	period_tracker tracker;
	int events_sent;
	int cycles;
	bit calm;

	input_capture_period_meter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long; none during calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Present one event, optionally after a gap, and hold it until accepted
	task automatic send_evt(input logic [1:0] cmd, input logic [STAMP_W-1:0] stamp);
		int gap;
		evt_t e;
		gap = pick_gap();
		e.command = cmd;
		e.capture_time = stamp;
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		events_sent++;
	endtask

	function automatic logic [STAMP_W-1:0] pick_stamp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return STAMP_W'($urandom);
	endfunction

	// Rearm, some overflows, then the closing capture, with the odd stray event mixed in
	task automatic send_measurement(input int n_ovf);
		send_evt(CMD_REARM, STAMP_W'($urandom));
		for (int i = 0; i < n_ovf; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_evt(CMD_UNUSED, STAMP_W'($urandom));
			send_evt(CMD_OVERFLOW, STAMP_W'($urandom));
		end
		send_evt(CMD_CAPTURE, pick_stamp());
		if ($urandom_range(0, 4) == 0)
			send_evt(CMD_CAPTURE, STAMP_W'($urandom));
	endtask

	// Result-side stall: random stalled and open stretches
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Observe accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && !evt_stall)
				tracker.note_event(evt);
			if (res_valid && !res_stall)
				tracker.check_result(res);
		end
	end

	// Run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				tracker.pending_results.size());
			$display("input_capture_period_meter_tb: errors");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int kind;
		int n_ovf;
		tracker = new();
		events_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first-edge handling, wrap of the stamp difference, events after done,
		// rearm in the done and second phases, unused command everywhere
		send_evt(CMD_OVERFLOW, 16'h0000);
		send_evt(CMD_OVERFLOW, 16'hFFFF);
		send_evt(CMD_UNUSED, 16'hFFFF);
		send_evt(CMD_CAPTURE, 16'hFFFF);  // first edge clears the overflow count
		send_evt(CMD_CAPTURE, 16'h0000);  // end below start wraps
		send_evt(CMD_OVERFLOW, 16'h5555);  // not counted when done
		send_evt(CMD_CAPTURE, 16'h1234);  // ignored when done
		send_evt(CMD_UNUSED, 16'hAAAA);
		send_evt(CMD_REARM, 16'hFFFF);
		send_evt(CMD_OVERFLOW, 16'h0000);
		send_evt(CMD_OVERFLOW, 16'h0000);
		send_evt(CMD_CAPTURE, 16'hFFFF);
		send_evt(CMD_REARM, 16'h0000);
		send_evt(CMD_CAPTURE, 16'hFFFF);  // zero-length period
		send_evt(CMD_REARM, 16'h0000);
		send_evt(CMD_UNUSED, 16'h0000);
		send_evt(CMD_REARM, 16'h0000);  // rearm while already armed
		send_evt(CMD_CAPTURE, 16'h8000);
		send_evt(CMD_REARM, 16'h0000);
		send_evt(CMD_CAPTURE, 16'h7FFF);

		// Overflow count runs into saturation
		send_measurement(300);

		// Random: mostly complete measurements, some loose events
		while (events_sent < RANDOM_EVENTS + 20) begin
			calm = ($urandom_range(0, 9) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				kind = $urandom_range(0, 99);
				if (kind < 86)
					n_ovf = $urandom_range(0, 4);
				else if (kind < 98)
					n_ovf = $urandom_range(5, 40);
				else
					n_ovf = $urandom_range(253, 260);
				send_measurement(n_ovf);
			end else begin
				repeat ($urandom_range(1, 4))
					send_evt(2'($urandom_range(0, 3)), STAMP_W'($urandom));
			end
		end
		calm = 1'b0;
		evt_valid <= 1'b0;

		// Drain
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d events; %0d periods measured, %0d overflows held at saturation",
			events_sent, tracker.periods_done, tracker.saturated_ovf);
		if (tracker.errors == 0)
			$display("input_capture_period_meter_tb: clean");
		else
			$display("input_capture_period_meter_tb: errors");
		$finish;
	end

endmodule
